@@ sv/aarch64_instruction_encoder_macros.svh @@
// Assertion macros shared by the A64 encoder RTL.
// Used by aarch64_instruction_encoder.sv; no other dependencies.
`ifndef AARCH64_INSTRUCTION_ENCODER_MACROS_SVH
`define AARCH64_INSTRUCTION_ENCODER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define AIE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define AIE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/aie_pkg.sv @@
// Shared types and opcode constants for the A64 instruction encoder.
// No dependencies.
package aie_pkg;

  localparam int unsigned AddrW = 21;
  localparam int unsigned MaxWords = 4;
  localparam logic [AddrW-1:0] CapReset = 21'd4096;

  typedef enum logic [4:0] {
    K_ADD_X    = 5'd0,
    K_ADD_W    = 5'd1,
    K_SUB_W    = 5'd2,
    K_MUL_W    = 5'd3,
    K_UDIV_W   = 5'd4,
    K_CMP_W    = 5'd5,
    K_CMP_X    = 5'd6,
    K_MOV_W    = 5'd7,
    K_MOV_X    = 5'd8,
    K_LSL_W    = 5'd9,
    K_CSET_W   = 5'd10,
    K_BLR      = 5'd11,
    K_RET      = 5'd12,
    K_MOVI_W   = 5'd13,
    K_MOVI_X   = 5'd14,
    K_LDR_W    = 5'd15,
    K_STR_W    = 5'd16,
    K_LDR_X    = 5'd17,
    K_STR_X    = 5'd18,
    K_ADDI_X   = 5'd19,
    K_SUBI_X   = 5'd20,
    K_BCOND    = 5'd21,
    K_B        = 5'd22,
    K_RESTART  = 5'd23
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  // opcode templates
  localparam logic [31:0] OpAddX  = 32'h8B00_0000;
  localparam logic [31:0] OpAddW  = 32'h0B00_0000;
  localparam logic [31:0] OpSubW  = 32'h4B00_0000;
  localparam logic [31:0] OpMulW  = 32'h1B00_7C00;
  localparam logic [31:0] OpUdivW = 32'h1AC0_0800;
  localparam logic [31:0] OpCmpW  = 32'h6B00_0000;
  localparam logic [31:0] OpCmpX  = 32'hEB00_0000;
  localparam logic [31:0] OpMovW  = 32'h2A00_03E0;
  localparam logic [31:0] OpMovX  = 32'hAA00_03E0;
  localparam logic [31:0] OpUbfmW = 32'h5300_0000;
  localparam logic [31:0] OpCsinc = 32'h1A80_0400;
  localparam logic [31:0] OpBlr   = 32'hD63F_0000;
  localparam logic [31:0] OpRet   = 32'hD65F_03C0;
  localparam logic [31:0] OpMovzW = 32'h5280_0000;
  localparam logic [31:0] OpMovkW = 32'h7280_0000;
  localparam logic [31:0] OpMovzX = 32'hD280_0000;
  localparam logic [31:0] OpMovkX = 32'hF280_0000;
  localparam logic [31:0] OpLdrW  = 32'hB940_0000;
  localparam logic [31:0] OpStrW  = 32'hB900_0000;
  localparam logic [31:0] OpLdrX  = 32'hF940_0000;
  localparam logic [31:0] OpStrX  = 32'hF900_0000;
  localparam logic [31:0] OpAddiX = 32'h9100_0000;
  localparam logic [31:0] OpSubiX = 32'hD100_0000;
  localparam logic [31:0] OpBcond = 32'h5400_0000;
  localparam logic [31:0] OpB     = 32'h1400_0000;

  typedef struct packed {
    logic [4:0]  kind;
    logic [4:0]  dest_reg;
    logic [4:0]  first_reg;
    logic [4:0]  second_reg;
    logic [3:0]  cond_code;
    logic [63:0] imm_value;
    logic [31:0] byte_offset;
  } item_t;

  // Encoder result: candidate words at fixed slots, a mask of slots to emit.
  typedef struct packed {
    logic [MaxWords-1:0][31:0] words;
    logic [MaxWords-1:0]       present;
    logic                      bad;
    logic                      restart;
  } enc_t;

endpackage

@@ sv/aie_encode.sv @@
// Combinational A64 encoder: one request in, up to four candidate words out.
// Depends on aie_pkg.
module aie_encode (
  input  aie_pkg::item_t item_i,
  output aie_pkg::enc_t  enc_o
);

  logic [4:0]  d, n, m;
  logic [31:0] off;
  logic [63:0] imm;
  logic [4:0]  sh;

  assign d   = item_i.dest_reg;
  assign n   = item_i.first_reg;
  assign m   = item_i.second_reg;
  assign off = item_i.byte_offset;
  assign imm = item_i.imm_value;
  assign sh  = imm[4:0];

  always_comb begin
    enc_o         = '0;
    enc_o.present = 4'b0001;
    unique case (aie_pkg::kind_e'(item_i.kind))
      aie_pkg::K_ADD_X:  enc_o.words[0] = aie_pkg::OpAddX  | {11'd0, m, 6'd0, n, d};
      aie_pkg::K_ADD_W:  enc_o.words[0] = aie_pkg::OpAddW  | {11'd0, m, 6'd0, n, d};
      aie_pkg::K_SUB_W:  enc_o.words[0] = aie_pkg::OpSubW  | {11'd0, m, 6'd0, n, d};
      aie_pkg::K_MUL_W:  enc_o.words[0] = aie_pkg::OpMulW  | {11'd0, m, 6'd0, n, d};
      aie_pkg::K_UDIV_W: enc_o.words[0] = aie_pkg::OpUdivW | {11'd0, m, 6'd0, n, d};
      aie_pkg::K_CMP_W:  enc_o.words[0] = aie_pkg::OpCmpW  | {11'd0, m, 6'd0, n, 5'd31};
      aie_pkg::K_CMP_X:  enc_o.words[0] = aie_pkg::OpCmpX  | {11'd0, m, 6'd0, n, 5'd31};
      aie_pkg::K_MOV_W:  enc_o.words[0] = aie_pkg::OpMovW  | {11'd0, n, 11'd0, d};
      aie_pkg::K_MOV_X:  enc_o.words[0] = aie_pkg::OpMovX  | {11'd0, n, 11'd0, d};
      aie_pkg::K_LSL_W: begin
        // UBFM: immr = -sh mod 32, imms = 31 - sh
        enc_o.bad      = |imm[63:5];
        enc_o.words[0] = aie_pkg::OpUbfmW | {11'd0, 5'(~sh + 5'd1), 1'b0, ~sh, n, d};
      end
      aie_pkg::K_CSET_W: begin
        // CSINC wd, wzr, wzr, invert(cond); AL/NV have no inverse
        enc_o.bad      = (item_i.cond_code[3:1] == 3'b111);
        enc_o.words[0] = aie_pkg::OpCsinc |
                         {11'd0, 5'd31, item_i.cond_code ^ 4'd1, 2'd0, 5'd31, d};
      end
      aie_pkg::K_BLR:    enc_o.words[0] = aie_pkg::OpBlr | {22'd0, n, 5'd0};
      aie_pkg::K_RET:    enc_o.words[0] = aie_pkg::OpRet;
      aie_pkg::K_MOVI_W: begin
        enc_o.words[0]   = aie_pkg::OpMovzW | {11'd0, imm[15:0], d};
        enc_o.words[1]   = aie_pkg::OpMovkW | {10'd0, 1'b1, imm[31:16], d};
        enc_o.present[1] = |imm[31:16];
      end
      aie_pkg::K_MOVI_X: begin
        enc_o.words[0]   = aie_pkg::OpMovzX | {11'd0, imm[15:0], d};
        enc_o.words[1]   = aie_pkg::OpMovkX | {9'd0, 2'd1, imm[31:16], d};
        enc_o.words[2]   = aie_pkg::OpMovkX | {9'd0, 2'd2, imm[47:32], d};
        enc_o.words[3]   = aie_pkg::OpMovkX | {9'd0, 2'd3, imm[63:48], d};
        enc_o.present[1] = |imm[31:16];
        enc_o.present[2] = |imm[47:32];
        enc_o.present[3] = |imm[63:48];
      end
      aie_pkg::K_LDR_W, aie_pkg::K_STR_W: begin
        enc_o.bad      = off[31] | (|off[1:0]) | (|off[30:12]);
        enc_o.words[0] = ((item_i.kind == aie_pkg::K_LDR_W) ? aie_pkg::OpLdrW
                                                            : aie_pkg::OpStrW) |
                         {12'd0, off[11:2], n, d};
      end
      aie_pkg::K_LDR_X, aie_pkg::K_STR_X: begin
        enc_o.bad      = off[31] | (|off[2:0]) | (|off[30:15]);
        enc_o.words[0] = ((item_i.kind == aie_pkg::K_LDR_X) ? aie_pkg::OpLdrX
                                                            : aie_pkg::OpStrX) |
                         {10'd0, off[14:3], n, d};
      end
      aie_pkg::K_ADDI_X, aie_pkg::K_SUBI_X: begin
        enc_o.bad      = |imm[63:12];
        enc_o.words[0] = ((item_i.kind == aie_pkg::K_ADDI_X) ? aie_pkg::OpAddiX
                                                             : aie_pkg::OpSubiX) |
                         {10'd0, imm[11:0], n, d};
      end
      aie_pkg::K_BCOND:   enc_o.words[0] = aie_pkg::OpBcond | {28'd0, item_i.cond_code};
      aie_pkg::K_B:       enc_o.words[0] = aie_pkg::OpB;
      aie_pkg::K_RESTART: enc_o.restart  = 1'b1;
      default:            enc_o.bad      = 1'b1;
    endcase
  end

endmodule

@@ sv/aarch64_instruction_encoder.sv @@
// A64 encoder with a running code address: input hold register, encoder, emitter.
// Depends on aie_pkg, aie_encode and aarch64_instruction_encoder_macros.svh.
//
// Usage: requests enter on the s_axis channel (kind in tuser, operands in tdata)
// and results leave on m_axis (word and byte address in tdata, status in tuser,
// tlast on the final result of a request). Each word advances the code address
// by 4; a word that would pass capacity_bytes gives a status-full result instead
// and ends the request. Bad operands give one status-invalid result.
// A request is held in the input hold register and each result goes out through the output register.
// Throughput: one result per cycle while m_axis_tready holds. Single-word requests
// go one per cycle; an immediate move holds the input register until its last word
// is emitted (up to four), since results come out of one output register in order.
// A restart request clears the code address and gives no result.
// Reset clears the code address, sets capacity to 4096, empties both registers.
// When the receiver stalls the output register holds its result, the emitter
// waits, and s_axis_tready drops once the held request cannot finish.
// Write the capacity register (cfg_we_i/cfg_wdata_i) only while idle; unchecked.
`include "aarch64_instruction_encoder_macros.svh"

module aarch64_instruction_encoder #(
  parameter int unsigned AddrW = aie_pkg::AddrW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [AddrW-1:0] cfg_wdata_i,    // capacity_bytes
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // dest_reg[4:0], first_reg[9:5], second_reg[14:10], cond_code[18:15],
  // imm_value[82:19], byte_offset[114:83], zero fill
  input  logic [119:0]     s_axis_tdata,
  input  logic [4:0]       s_axis_tuser,   // kind[4:0]
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // word[31:0], word_address[32+AddrW-1:32], zero fill to whole bytes
  output logic [((32+AddrW+7)/8)*8-1:0] m_axis_tdata,
  output logic [1:0]       m_axis_tuser,   // status[1:0]
  output logic             m_axis_tlast
);

  localparam int unsigned OutW = ((32 + AddrW + 7) / 8) * 8;

  logic [AddrW-1:0] cap_q, addr_q, addr_d;
  logic             hv_q, hv_d;
  logic [1:0]       idx_q, idx_d;
  aie_pkg::item_t   item_q;
  aie_pkg::enc_t    enc;

  logic             ov_q, ov_d;
  logic [31:0]      word_q, word_d;
  logic [AddrW-1:0] oaddr_q, oaddr_d;
  logic [1:0]       st_q, st_d;
  logic             last_q, last_d;
  logic             load_out;

  logic             out_free, step, done, accept, more, room;
  logic [1:0]       nxt;
  logic             err_out, err_shape, adv;

  aie_encode u_encode (
    .item_i (item_q),
    .enc_o  (enc)
  );

  assign out_free      = !ov_q || m_axis_tready;
  assign step          = hv_q && out_free;
  assign s_axis_tready = !hv_q || (step && done);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign room          = ({1'b0, addr_q} + (AddrW+1)'(4)) <= {1'b0, cap_q};

  // next slot to emit after the current one
  always_comb begin
    nxt  = idx_q;
    more = 1'b0;
    for (int j = aie_pkg::MaxWords - 1; j >= 0; j--) begin
      if (j > int'(idx_q) && enc.present[j]) begin
        nxt  = 2'(j);
        more = 1'b1;
      end
    end
  end

  always_comb begin
    done     = 1'b0;
    addr_d   = addr_q;
    idx_d    = idx_q;
    load_out = 1'b0;
    word_d   = '0;
    oaddr_d  = addr_q;
    st_d     = aie_pkg::ST_OK;
    last_d   = 1'b1;
    if (step) begin
      priority if (enc.restart) begin
        addr_d = '0;
        done   = 1'b1;
      end else if (enc.bad) begin
        load_out = 1'b1;
        st_d     = aie_pkg::ST_INVALID;
        done     = 1'b1;
      end else if (!room) begin
        load_out = 1'b1;
        st_d     = aie_pkg::ST_FULL;
        done     = 1'b1;
      end else begin
        load_out = 1'b1;
        word_d   = enc.words[idx_q];
        last_d   = !more;
        addr_d   = addr_q + AddrW'(4);
        if (more) begin
          idx_d = nxt;
        end else begin
          done = 1'b1;
        end
      end
    end
    if (accept) begin
      idx_d = '0;
    end
  end

  always_comb begin
    hv_d = hv_q;
    if (accept) begin
      hv_d = 1'b1;
    end else if (step && done) begin
      hv_d = 1'b0;
    end
    ov_d = load_out ? 1'b1 : (ov_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= AddrW'(aie_pkg::CapReset);
      addr_q <= '0;
      hv_q   <= 1'b0;
      idx_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      addr_q <= addr_d;
      hv_q   <= hv_d;
      idx_q  <= idx_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.kind        <= s_axis_tuser;
      item_q.dest_reg    <= s_axis_tdata[4:0];
      item_q.first_reg   <= s_axis_tdata[9:5];
      item_q.second_reg  <= s_axis_tdata[14:10];
      item_q.cond_code   <= s_axis_tdata[18:15];
      item_q.imm_value   <= s_axis_tdata[82:19];
      item_q.byte_offset <= s_axis_tdata[114:83];
    end
    if (load_out) begin
      word_q  <= word_d;
      oaddr_q <= oaddr_d;
      st_q    <= st_d;
      last_q  <= last_d;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {(OutW - 32 - AddrW)'(0), oaddr_q, word_q};
  assign m_axis_tuser  = st_q;
  assign m_axis_tlast  = last_q;

  assign err_out   = m_axis_tvalid && (m_axis_tuser != aie_pkg::ST_OK);
  assign err_shape = (m_axis_tdata[31:0] == 32'd0) && m_axis_tlast;
  assign adv       = step && !enc.restart && !enc.bad && room;

  `AIE_ASSERT_NOW(a_err_zero_last, err_out, err_shape, "error result needs zero word, tlast")
  `AIE_ASSERT_NOW(a_status_legal, m_axis_tvalid, m_axis_tuser <= aie_pkg::ST_FULL, "bad status")
  `AIE_ASSERT_NEXT(a_addr_step, adv, addr_q == $past(addr_q) + AddrW'(4), "address step")

endmodule

@@ bench/tb_aarch64_instruction_encoder.sv @@
// Self-checking bench for aarch64_instruction_encoder: directed and random requests,
// predicted A64 words and addresses checked in order. Depends on aie_pkg and the RTL.
`timescale 1ns / 100ps

module tb_aarch64_instruction_encoder;
  import aie_pkg::*;

  typedef struct {
    logic [31:0]      word;
    logic [AddrW-1:0] addr;
    status_e          status;
    logic             last;
  } result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [AddrW-1:0] cfg_wdata_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [119:0]     s_axis_tdata;
  logic [4:0]       s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [55:0]      m_axis_tdata;
  logic [1:0]       m_axis_tuser;
  logic             m_axis_tlast;

  result_t          expected_words[$];
  logic [AddrW-1:0] capacity_model;
  logic [AddrW-1:0] code_addr_model;
  int               n_errors;
  bit               no_idle;

  aarch64_instruction_encoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #400_000;
    $display("tb_aarch64_instruction_encoder: done, errors");
    $finish;
  end

  function automatic logic [31:0] reg_form(input logic [31:0] base, input logic [31:0] d,
                                           input logic [31:0] n, input logic [31:0] m);
    return base | (m << 16) | (n << 5) | d;
  endfunction

  // Append one expected result to the tail of the queue.
  function automatic void queue_result(input result_t res);
    expected_words.insert(expected_words.size(), res);
  endfunction

  // Expected words for one accepted request; updates the code address copy.
  function automatic void predict_encoding(input item_t req);
    logic [31:0] words [4];
    int          cnt;
    bit          bad;
    logic [31:0] d, n, m, off;
    logic [15:0] half;
    logic [4:0]  immr, imms;
    result_t     res;
    d = 32'(req.dest_reg);
    n = 32'(req.first_reg);
    m = 32'(req.second_reg);
    off = req.byte_offset;
    cnt = 1;
    bad = 1'b0;
    words[0] = '0;
    case (req.kind)
      K_ADD_X:  words[0] = reg_form(OpAddX, d, n, m);
      K_ADD_W:  words[0] = reg_form(OpAddW, d, n, m);
      K_SUB_W:  words[0] = reg_form(OpSubW, d, n, m);
      K_MUL_W:  words[0] = reg_form(OpMulW, d, n, m);
      K_UDIV_W: words[0] = reg_form(OpUdivW, d, n, m);
      K_CMP_W:  words[0] = reg_form(OpCmpW, 32'd31, n, m);
      K_CMP_X:  words[0] = reg_form(OpCmpX, 32'd31, n, m);
      K_MOV_W:  words[0] = OpMovW | (n << 16) | d;
      K_MOV_X:  words[0] = OpMovX | (n << 16) | d;
      K_LSL_W: begin
        bad = req.imm_value > 64'd31;
        immr = 5'd0 - req.imm_value[4:0];   // (32 - shift) mod 32
        imms = 5'd31 - req.imm_value[4:0];
        words[0] = OpUbfmW | (32'(immr) << 16) | (32'(imms) << 10) | (n << 5) | d;
      end
      K_CSET_W: begin
        // CSINC with the inverted condition; AL and NV have no inverse
        bad = req.cond_code >= 4'd14;
        words[0] = OpCsinc | (32'(req.cond_code ^ 4'd1) << 12) | (32'd31 << 16)
                   | (32'd31 << 5) | d;
      end
      K_BLR:    words[0] = OpBlr | (n << 5);
      K_RET:    words[0] = OpRet;
      K_MOVI_W: begin
        words[0] = OpMovzW | (32'(req.imm_value[15:0]) << 5) | d;
        if (req.imm_value[31:16] != 16'd0) begin
          words[1] = OpMovkW | (32'd1 << 21) | (32'(req.imm_value[31:16]) << 5) | d;
          cnt = 2;
        end
      end
      K_MOVI_X: begin
        words[0] = OpMovzX | (32'(req.imm_value[15:0]) << 5) | d;
        for (int i = 1; i < 4; i++) begin
          half = req.imm_value[16*i +: 16];
          if (half != 16'd0) begin
            words[cnt] = OpMovkX | (32'(i) << 21) | (32'(half) << 5) | d;
            cnt++;
          end
        end
      end
      K_LDR_W, K_STR_W: begin
        bad = off[31] || off[1:0] != 2'd0 || off > 32'd4092;
        words[0] = ((req.kind == K_LDR_W) ? OpLdrW : OpStrW) | ((off >> 2) << 10)
                   | (n << 5) | d;
      end
      K_LDR_X, K_STR_X: begin
        bad = off[31] || off[2:0] != 3'd0 || off > 32'd32760;
        words[0] = ((req.kind == K_LDR_X) ? OpLdrX : OpStrX) | ((off >> 3) << 10)
                   | (n << 5) | d;
      end
      K_ADDI_X, K_SUBI_X: begin
        bad = req.imm_value > 64'd4095;
        words[0] = ((req.kind == K_ADDI_X) ? OpAddiX : OpSubiX)
                   | (32'(req.imm_value[11:0]) << 10) | (n << 5) | d;
      end
      K_BCOND:  words[0] = OpBcond | 32'(req.cond_code);
      K_B:      words[0] = OpB;
      K_RESTART: begin
        code_addr_model = '0;
        return;
      end
      default:  bad = 1'b1;
    endcase

    if (bad) begin
      res = '{word: '0, addr: code_addr_model, status: ST_INVALID, last: 1'b1};
      queue_result(res);
      return;
    end
    for (int i = 0; i < cnt; i++) begin
      if (32'(code_addr_model) + 32'd4 > 32'(capacity_model)) begin
        res = '{word: '0, addr: code_addr_model, status: ST_FULL, last: 1'b1};
        queue_result(res);
        break;
      end
      res = '{word: words[i], addr: code_addr_model, status: ST_OK, last: (i == cnt - 1)};
      queue_result(res);
      code_addr_model = code_addr_model + AddrW'(4);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $error("result with no request pending: tdata 0x%0h", m_axis_tdata);
        n_errors++;
      end else begin
        want = expected_words.pop_front();
        check_field("word", want.word, m_axis_tdata[31:0]);
        check_field("word_address", 32'(want.addr), 32'(m_axis_tdata[32 +: AddrW]));
        check_field("status", 32'(want.status), 32'(m_axis_tuser));
        check_field("last", 32'(want.last), 32'(m_axis_tlast));
      end
    end
  end

  // Receiver: random stall bursts.
  initial begin : drive_ready
    int burst;
    burst = 0;
    m_axis_tready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (burst > 0) begin
        m_axis_tready <= 1'b0;
        burst--;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 9) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic item_t make_request(input logic [4:0] kind, input logic [4:0] d,
                                         input logic [4:0] n, input logic [4:0] m,
                                         input logic [3:0] cond, input logic [63:0] imm,
                                         input logic [31:0] off);
    item_t r;
    r.kind = kind;
    r.dest_reg = d;
    r.first_reg = n;
    r.second_reg = m;
    r.cond_code = cond;
    r.imm_value = imm;
    r.byte_offset = off;
    return r;
  endfunction

  // Mostly well-formed operands; some unknown kinds, restarts and raw noise.
  function automatic item_t random_request();
    item_t r;
    int    pick;
    r = make_request(5'($urandom_range(0, 22)), 5'($urandom), 5'($urandom), 5'($urandom),
                     4'($urandom), {$urandom, $urandom}, $urandom);
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      r.kind = 5'($urandom_range(24, 31));
    end else if (pick < 8) begin
      r.kind = K_RESTART;
    end else if (pick < 85) begin
      case (r.kind)
        K_LSL_W:            r.imm_value = 64'($urandom_range(0, 31));
        K_CSET_W:           r.cond_code = 4'($urandom_range(0, 13));
        K_LDR_W, K_STR_W:   r.byte_offset = 32'($urandom_range(0, 1023)) << 2;
        K_LDR_X, K_STR_X:   r.byte_offset = 32'($urandom_range(0, 4095)) << 3;
        K_ADDI_X, K_SUBI_X: r.imm_value = 64'($urandom_range(0, 4095));
        K_MOVI_W, K_MOVI_X: begin
          for (int i = 0; i < 4; i++)
            if ($urandom_range(0, 2) == 0) r.imm_value[16*i +: 16] = '0;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input item_t req);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req.kind;
    s_axis_tdata <= {5'd0, req.byte_offset, req.imm_value, req.cond_code,
                     req.second_reg, req.first_reg, req.dest_reg};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_encoding(req);
    @(negedge clk_i);
  endtask

  task automatic wait_until_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    // a trailing restart gives no result, so give the pipeline time to settle
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_capacity(input logic [AddrW-1:0] cap);
    wait_until_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    capacity_model = cap;
  endtask

  task automatic test_register_ops();
    logic [4:0] ops [7] = '{K_SUB_W, K_MUL_W, K_UDIV_W, K_CMP_W, K_CMP_X, K_MOV_W, K_MOV_X};
    send_request(make_request(K_ADD_X, 5'd31, 5'd0, 5'd31, 4'd0, '0, '0));
    send_request(make_request(K_ADD_W, 5'd0, 5'd31, 5'd0, 4'd15, '1, '1));
    foreach (ops[i])
      send_request(make_request(ops[i], 5'($urandom), 5'($urandom), 5'($urandom),
                                4'($urandom), {$urandom, $urandom}, $urandom));
  endtask

  task automatic test_shift_and_cset();
    send_request(make_request(K_LSL_W, 5'd3, 5'd4, 5'd0, 4'd0, 64'd31, '0));
    send_request(make_request(K_LSL_W, 5'd3, 5'd4, 5'd0, 4'd0, 64'd32, '0));
    send_request(make_request(K_CSET_W, 5'd7, 5'd0, 5'd0, 4'd0, '0, '0));
    send_request(make_request(K_CSET_W, 5'd7, 5'd0, 5'd0, 4'd14, '0, '0));
    send_request(make_request(K_CSET_W, 5'd7, 5'd0, 5'd0, 4'd15, '0, '0));
  endtask

  task automatic test_immediate_moves();
    // narrow move ignores the upper 32 bits
    send_request(make_request(K_MOVI_W, 5'd1, 5'd0, 5'd0, 4'd0, '1, '0));
    send_request(make_request(K_MOVI_W, 5'd2, 5'd0, 5'd0, 4'd0, 64'h1234_0000_0000_0000, '0));
    send_request(make_request(K_MOVI_X, 5'd31, 5'd0, 5'd0, 4'd0, '1, '0));
    send_request(make_request(K_MOVI_X, 5'd0, 5'd0, 5'd0, 4'd0, 64'h0001_0000_0000_0000, '0));
  endtask

  task automatic test_memory_offsets();
    send_request(make_request(K_LDR_W, 5'd5, 5'd31, 5'd0, 4'd0, '0, 32'd4092));
    send_request(make_request(K_STR_W, 5'd5, 5'd31, 5'd0, 4'd0, '0, 32'd4096));
    send_request(make_request(K_STR_W, 5'd5, 5'd0, 5'd0, 4'd0, '0, 32'd6));
    send_request(make_request(K_LDR_X, 5'd9, 5'd2, 5'd0, 4'd0, '0, 32'd32760));
    send_request(make_request(K_STR_X, 5'd9, 5'd2, 5'd0, 4'd0, '0, -32'sd8));
    send_request(make_request(K_LDR_X, 5'd9, 5'd2, 5'd0, 4'd0, '0, 32'h8000_0000));
  endtask

  task automatic test_add_sub_immediate();
    send_request(make_request(K_ADDI_X, 5'd8, 5'd31, 5'd0, 4'd0, 64'd4095, '0));
    send_request(make_request(K_SUBI_X, 5'd8, 5'd31, 5'd0, 4'd0, 64'd4096, '0));
  endtask

  task automatic test_control_flow();
    send_request(make_request(K_BLR, 5'd0, 5'd31, 5'd0, 4'd0, '0, '0));
    send_request(make_request(K_RET, 5'd0, 5'd0, 5'd0, 4'd0, '0, '0));
    send_request(make_request(K_BCOND, 5'd0, 5'd0, 5'd0, 4'd15, '0, '0));
    send_request(make_request(K_B, 5'd0, 5'd0, 5'd0, 4'd0, '0, '0));
    send_request(make_request(5'd24, 5'd0, 5'd0, 5'd0, 4'd0, '0, '0));
    send_request(make_request(5'd31, 5'd0, 5'd0, 5'd0, 4'd0, '0, '0));
    send_request(make_request(K_RESTART, 5'd0, 5'd0, 5'd0, 4'd0, '0, '0));
    send_request(make_request(K_ADD_X, 5'd1, 5'd2, 5'd3, 4'd0, '0, '0));
  endtask

  task automatic test_capacity_limits();
    set_capacity('0);
    send_request(make_request(K_ADD_W, 5'd1, 5'd1, 5'd1, 4'd0, '0, '0));
    set_capacity(AddrW'(8));
    send_request(make_request(K_RESTART, 5'd0, 5'd0, 5'd0, 4'd0, '0, '0));
    // two words fit, the third hits the limit
    send_request(make_request(K_MOVI_X, 5'd4, 5'd0, 5'd0, 4'd0, '1, '0));
    send_request(make_request(K_LSL_W, 5'd0, 5'd0, 5'd0, 4'd0, 64'd40, '0));
    set_capacity(AddrW'(6));
    send_request(make_request(K_RESTART, 5'd0, 5'd0, 5'd0, 4'd0, '0, '0));
    send_request(make_request(K_MOVI_W, 5'd4, 5'd0, 5'd0, 4'd0, 64'hFFFF_FFFF, '0));
  endtask

  task automatic test_random_traffic(input logic [AddrW-1:0] cap, input int count,
                                     input bit quiet);
    set_capacity(cap);
    no_idle = quiet;
    repeat (count) send_request(random_request());
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    capacity_model = CapReset;
    code_addr_model = '0;
    n_errors = 0;
    no_idle = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_register_ops();
    test_shift_and_cset();
    test_immediate_moves();
    test_memory_offsets();
    test_add_sub_immediate();
    test_control_flow();
    test_capacity_limits();
    test_random_traffic(AddrW'($urandom_range(16, 400)), 55, 1'b0);
    test_random_traffic(CapReset, 55, 1'b0);
    test_random_traffic(AddrW'($urandom_range(0, 1048576)), 55, 1'b0);
    test_random_traffic(AddrW'(1048576), 55, 1'b1);

    wait_until_drained();
    if (n_errors == 0 && expected_words.size() == 0) begin
      $display("tb_aarch64_instruction_encoder: done, clean");
    end else begin
      $display("tb_aarch64_instruction_encoder: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/aie_pkg.sv
sv/aie_encode.sv
sv/aarch64_instruction_encoder.sv
bench/tb_aarch64_instruction_encoder.sv
